/* hw/rtl/ir_pulse_width_capture_defines.svh */
// assertion macros shared by the checker of the ir pulse width capture block
`ifndef IR_PULSE_WIDTH_CAPTURE_DEFINES_SVH
`define IR_PULSE_WIDTH_CAPTURE_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define IRPWC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define IRPWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/irpwc_pkg.sv */
// shared types and constants of the ir pulse width capture block
`timescale 1ns / 1ps

package irpwc_pkg;

    // buffer sizing
    localparam int DEFAULT_BUFFER_DEPTH = 256;
    localparam int STORE_LIMIT_MAX      = 255;

    // field widths
    localparam int WIDTH_W   = 8;
    localparam int COUNT_W   = 8;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // transaction kinds carried on s_tuser
    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_ARM  = 2'd1,
        ACT_READ = 2'd2
    } action_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_ON_RISING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT       = 2'd2;

    // configuration reset values
    localparam logic                RST_START_ON_RISING = 1'b0;
    localparam logic [TICK_W-1:0]   RST_TIMEOUT_TICKS   = 16'hFFFF;
    localparam logic [COUNT_W-1:0]  RST_MIN_COUNT       = 8'd10;

endpackage

/* hw/rtl/ir_pulse_width_capture.sv */
// top level of the ir pulse width capture block
// latency: a transaction accepted at one edge shows its result on m_* from the next cycle
// throughput: one transaction per cycle; s_tready drops only while a result is stalled
// the edge detect, tick counter, buffer write and buffer read all act on the transaction as it is accepted
// reset: synchronous active-low, returns to idle, armed, line high, no stored entries
// the buffer itself is not cleared; entries at or above the count always read as zero
`timescale 1ns / 1ps

module ir_pulse_width_capture #(
    parameter int BUFFER_DEPTH = irpwc_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [irpwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irpwc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,  // [0] line_level, [8:1] read_index
    input  logic [1:0]                       s_tuser,  // [1:0] action
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] capture_done, [8:1] entry_count, [16:9] read_data, [17] receiver_armed
    output logic [23:0]                      m_tdata
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int STORE_LIMIT_INT = (BUFFER_DEPTH > irpwc_pkg::STORE_LIMIT_MAX) ?
                                     irpwc_pkg::STORE_LIMIT_MAX : BUFFER_DEPTH;
    localparam logic [irpwc_pkg::COUNT_W-1:0] STORE_LIMIT =
        irpwc_pkg::COUNT_W'(STORE_LIMIT_INT);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_RISE,
        PH_WAIT_FALL
    } phase_t;

    // configuration registers
    logic                              start_on_rising_reg;
    logic [irpwc_pkg::TICK_W-1:0]      timeout_reg;
    logic [irpwc_pkg::COUNT_W-1:0]     min_count_reg;

    // capture state
    phase_t                            phase_reg, phase_next;
    logic                              armed_reg, armed_next;
    logic [irpwc_pkg::TICK_W-1:0]      tick_cnt_reg, tick_cnt_next;
    logic [irpwc_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic                              prev_level_reg, prev_level_next;

    // result register
    logic                              m_valid_reg;
    logic                              done_reg, done_next;
    logic                              hit_reg, hit_next;

    // decoded input
    logic                              in_accept;
    irpwc_pkg::action_t                action;
    logic                              level;
    logic [irpwc_pkg::COUNT_W-1:0]     read_index;

    logic                              rise;
    logic                              fall;
    logic                              expected;
    logic [irpwc_pkg::TICK_W-1:0]      tick_inc;
    logic                              wr_en;
    logic                              rd_en;
    logic [irpwc_pkg::WIDTH_W-1:0]     mem_rdata;

    assign in_accept  = s_tvalid && s_tready;
    assign action     = irpwc_pkg::action_t'(s_tuser);
    assign level      = s_tdata[0];
    assign read_index = s_tdata[8:1];

    // output slot frees as the held result is taken
    assign s_tready = !m_valid_reg || m_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_on_rising_reg <= irpwc_pkg::RST_START_ON_RISING;
            timeout_reg         <= irpwc_pkg::RST_TIMEOUT_TICKS;
            min_count_reg       <= irpwc_pkg::RST_MIN_COUNT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                irpwc_pkg::CFG_START_ON_RISING: start_on_rising_reg <= cfg_wdata[0];
                irpwc_pkg::CFG_TIMEOUT_TICKS:   timeout_reg <= cfg_wdata;
                irpwc_pkg::CFG_MIN_COUNT:       min_count_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // edge detect and saturating tick count
    assign rise     = !prev_level_reg && level;
    assign fall     = prev_level_reg && !level;
    assign expected = (phase_reg == PH_WAIT_RISE) ? rise : fall;
    assign tick_inc = (tick_cnt_reg != irpwc_pkg::TICK_MAX) ?
                      tick_cnt_reg + 1'b1 : tick_cnt_reg;

    // next state for one transaction
    always_comb begin
        phase_next      = phase_reg;
        armed_next      = armed_reg;
        tick_cnt_next   = tick_cnt_reg;
        count_next      = count_reg;
        prev_level_next = prev_level_reg;
        done_next       = 1'b0;
        hit_next        = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        if (in_accept) begin
            case (action)
                irpwc_pkg::ACT_TICK: begin
                    prev_level_next = level;
                    if (armed_reg) begin
                        if (phase_reg == PH_IDLE) begin
                            if (start_on_rising_reg ? rise : fall) begin
                                phase_next    = start_on_rising_reg ? PH_WAIT_FALL
                                                                    : PH_WAIT_RISE;
                                count_next    = '0;
                                tick_cnt_next = '0;
                            end
                        end else begin
                            tick_cnt_next = tick_inc;
                            if (expected && (count_reg < STORE_LIMIT)) begin
                                wr_en         = 1'b1;
                                count_next    = count_reg + 1'b1;
                                tick_cnt_next = '0;
                                phase_next    = (phase_reg == PH_WAIT_RISE) ? PH_WAIT_FALL
                                                                            : PH_WAIT_RISE;
                            end else if (tick_inc >= timeout_reg) begin
                                if (count_reg > min_count_reg) begin
                                    done_next  = 1'b1;
                                    armed_next = 1'b0;
                                end
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
                irpwc_pkg::ACT_ARM: begin
                    armed_next = 1'b1;
                    phase_next = PH_IDLE;
                end
                irpwc_pkg::ACT_READ: begin
                    rd_en    = 1'b1;
                    hit_next = read_index < count_reg;
                end
                default: ;
            endcase
        end
    end

    // state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            armed_reg      <= 1'b1;
            tick_cnt_reg   <= '0;
            count_reg      <= '0;
            prev_level_reg <= 1'b1;
            m_valid_reg    <= 1'b0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            armed_reg      <= armed_next;
            tick_cnt_reg   <= tick_cnt_next;
            count_reg      <= count_next;
            prev_level_reg <= prev_level_next;
            if (in_accept) begin
                m_valid_reg <= 1'b1;
                done_reg    <= done_next;
                hit_reg     <= hit_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // pulse width buffer
    irpwc_width_mem #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_width_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(count_reg)),
        .wr_data (tick_inc[irpwc_pkg::WIDTH_W-1:0]),
        .rd_en   (rd_en),
        .rd_addr (ADDR_W'(read_index)),
        .rd_data (mem_rdata)
    );

    // result packing; count and armed are the state after the last transaction
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0,
                       armed_reg,
                       hit_reg ? mem_rdata : {irpwc_pkg::WIDTH_W{1'b0}},
                       count_reg,
                       done_reg};

endmodule

/* hw/rtl/irpwc_width_mem.sv */
// pulse width buffer: one write port, one registered read port
`timescale 1ns / 1ps

module irpwc_width_mem #(
    parameter int DEPTH  = irpwc_pkg::DEFAULT_BUFFER_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [irpwc_pkg::WIDTH_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [irpwc_pkg::WIDTH_W-1:0] rd_data
);

    logic [irpwc_pkg::WIDTH_W-1:0] mem [DEPTH];
    logic [irpwc_pkg::WIDTH_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/irpwc_checker.sv */
// port-level assertions for the ir pulse width capture block
`timescale 1ns / 1ps
`include "ir_pulse_width_capture_defines.svh"

module irpwc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [1:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [23:0]                      m_tdata
);

    logic in_accept;
    logic out_done;
    logic out_armed;
    logic [7:0] out_rdata;

    assign in_accept = s_tvalid && s_tready;
    assign out_done  = m_tdata[0];
    assign out_rdata = m_tdata[16:9];
    assign out_armed = m_tdata[17];

    // a stalled result holds
    `IRPWC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result changed")

    // a reported capture disarms the receiver
    `IRPWC_ASSERT_SAME(a_done_disarms, aclk, aresetn, m_tvalid && out_done,
        !out_armed, "capture done while still armed")

    // arming shows up armed in the very next result
    `IRPWC_ASSERT_NEXT(a_arm_result, aclk, aresetn,
        in_accept && (s_tuser == irpwc_pkg::ACT_ARM),
        m_tvalid && out_armed && !out_done, "arm transaction did not arm")

    // only reads return buffer data
    `IRPWC_ASSERT_NEXT(a_rdata_zero, aclk, aresetn,
        in_accept && (s_tuser != irpwc_pkg::ACT_READ),
        m_tvalid && (out_rdata == 8'd0), "read data on a non-read transaction")

endmodule

bind ir_pulse_width_capture irpwc_checker u_irpwc_checker (.*);
